// ===== sv/sync_length_sum_frame_receiver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SYNC_LENGTH_SUM_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SLSFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SLSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLSFR_ASSERT_SAME(label, ante, cons, msg)
`define SLSFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/slsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slsfr_pkg
// Shared widths, register codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package slsfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  reg_idx_t;

  localparam reg_idx_t REG_FIRST_SYNC   = 2'd0;
  localparam reg_idx_t REG_SECOND_SYNC  = 2'd1;
  localparam reg_idx_t REG_LENGTH_LIMIT = 2'd2;

  localparam byte_t FIRST_SYNC_RST   = 8'hAA;
  localparam byte_t SECOND_SYNC_RST  = 8'hBB;
  localparam len_t  LENGTH_LIMIT_RST = len_t'(MAX_PAYLOAD);

  // controller -> datapath
  typedef struct packed {
    logic len_load;    // length byte accepted, start frame
    logic data_store;  // store payload byte, add to sum
    logic rd_clear;    // rewind read pointer for drain
    logic rd_issue;    // read store at read pointer
    logic out_load;    // move read data into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sync1_match;
    logic sync2_match;
    logic len_ok;
    logic data_done;
    logic sum_match;
    logic rd_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/slsfr_if.sv =====
// ----------------------------------------------------------------------------
// slsfr_in_if / slsfr_out_if
// Valid/ready channels for received bytes and checked payload bytes.
// ----------------------------------------------------------------------------
interface slsfr_in_if;
  import slsfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

interface slsfr_out_if;
  import slsfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  addr_t byte_position;
  len_t  frame_length;
  logic  last;

  modport source (output valid, output payload_byte, output byte_position,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input payload_byte, input byte_position,
                  input frame_length, input last, output ready);
endinterface

// ===== sv/slsfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// slsfr_ctrl
// Frame state machine: sync hunt, length, payload, check and drain.
// ----------------------------------------------------------------------------
`include "sync_length_sum_frame_receiver_unit_macros.svh"

module slsfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slsfr_pkg::dp_sts_t  sts,
  output slsfr_pkg::ctl_cmd_t cmd
);
  import slsfr_pkg::*;

  localparam logic [2:0] ST_SYNC1 = 3'd0;
  localparam logic [2:0] ST_SYNC2 = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r != ST_RD) && (state_r != ST_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_SYNC1: begin
        if (accept && sts.sync1_match) state_nxt = ST_SYNC2;
      end
      ST_SYNC2: begin
        if (accept) state_nxt = sts.sync2_match ? ST_LEN : ST_SYNC1;
      end
      ST_LEN: begin
        if (accept) begin
          cmd.len_load = sts.len_ok;
          state_nxt    = sts.len_ok ? ST_DATA : ST_SYNC1;
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd.data_store = 1'b1;
          if (sts.data_done) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (accept) begin
          cmd.rd_clear = sts.sum_match;
          state_nxt    = sts.sum_match ? ST_RD : ST_SYNC1;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.rd_last ? ST_SYNC1 : ST_RD;
        end
      end
      default: state_nxt = ST_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SLSFR_ASSERT_NEXT(a_rd_then_load, state_r == ST_RD, state_r == ST_LOAD, "read not followed by load")
  `SLSFR_ASSERT_SAME(a_load_when_free, cmd.out_load, sts.out_free, "output loaded while occupied")

endmodule

// ===== sv/slsfr_dp.sv =====
// ----------------------------------------------------------------------------
// slsfr_dp
// Config registers, byte compares, payload store, running sum, output register.
// ----------------------------------------------------------------------------
`include "sync_length_sum_frame_receiver_unit_macros.svh"

module slsfr_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  slsfr_pkg::reg_idx_t  cfg_index,
  input  slsfr_pkg::byte_t     cfg_wdata,
  input  slsfr_pkg::byte_t     rx_data,
  input  slsfr_pkg::ctl_cmd_t  cmd,
  output slsfr_pkg::dp_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slsfr_pkg::byte_t     out_payload_byte,
  output slsfr_pkg::addr_t     out_byte_position,
  output slsfr_pkg::len_t      out_frame_length,
  output logic                 out_last
);
  import slsfr_pkg::*;

  byte_t first_sync_r, second_sync_r;
  len_t  length_limit_r;
  len_t  eff_limit;

  len_t  exp_len_r;
  len_t  cnt_r;
  byte_t sum_r;
  addr_t rd_idx_r;
  byte_t mem_q_r;
  byte_t store_mem [MAX_PAYLOAD];

  logic  out_valid_r;
  byte_t out_byte_r;
  addr_t out_pos_r;
  len_t  out_len_r;
  logic  out_last_r;
  len_t  cnt_inc;
  len_t  rd_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r   <= FIRST_SYNC_RST;
      second_sync_r  <= SECOND_SYNC_RST;
      length_limit_r <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_SYNC:   first_sync_r   <= cfg_wdata;
        REG_SECOND_SYNC:  second_sync_r  <= cfg_wdata;
        REG_LENGTH_LIMIT: length_limit_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_limit = (length_limit_r > len_t'(MAX_PAYLOAD)) ? len_t'(MAX_PAYLOAD)
                                                            : length_limit_r;
  assign cnt_inc   = cnt_r + len_t'(1);
  assign rd_inc    = {1'b0, rd_idx_r} + len_t'(1);

  assign sts.sync1_match = (rx_data == first_sync_r);
  assign sts.sync2_match = (rx_data == second_sync_r);
  assign sts.len_ok      = (rx_data != '0) && (rx_data <= {{(BYTE_W-LEN_W){1'b0}}, eff_limit});
  assign sts.data_done   = (cnt_inc >= exp_len_r);
  assign sts.sum_match   = (rx_data == sum_r);
  assign sts.rd_last     = (rd_inc == exp_len_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      rd_idx_r  <= '0;
    end else begin
      if (cmd.len_load) begin
        exp_len_r <= rx_data[LEN_W-1:0];
        cnt_r     <= '0;
        sum_r     <= '0;
      end else if (cmd.data_store) begin
        cnt_r <= cnt_inc;
        sum_r <= sum_r + rx_data;
      end
      if (cmd.rd_clear) begin
        rd_idx_r <= '0;
      end else if (cmd.out_load) begin
        rd_idx_r <= rd_inc[ADDR_W-1:0];
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (cmd.data_store) store_mem[cnt_r[ADDR_W-1:0]] <= rx_data;
    if (cmd.rd_issue) mem_q_r <= store_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= mem_q_r;
      out_pos_r  <= rd_idx_r;
      out_len_r  <= exp_len_r;
      out_last_r <= sts.rd_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_length  = out_len_r;
  assign out_last          = out_last_r;

  `SLSFR_ASSERT_NEXT(a_last_marked, cmd.out_load && sts.rd_last, out_last_r && out_valid_r, "last byte not marked")
  `SLSFR_ASSERT_SAME(a_store_in_range, cmd.data_store, cnt_r < exp_len_r, "payload write past frame length")

endmodule

// ===== sv/sync_length_sum_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit
// Two-byte sync, length and checksum deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the block hunts for the two
// sync bytes, reads the length byte, collects payload and compares the check
// byte against the modulo-256 sum of the payload. A frame that passes is sent
// out from the internal 32-byte store, one transaction per payload byte with
// last set on the final one; a frame that fails is dropped silently. While a
// frame drains the input is stalled: each payload byte takes a registered
// store read and then an output register load, and the input is held longer
// still if the output side stalls. The input is open again once the last
// byte sits in the output register.
module sync_length_sum_frame_receiver_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  slsfr_pkg::reg_idx_t cfg_index,
  input  slsfr_pkg::byte_t    cfg_wdata,
  slsfr_in_if.sink            in_if,
  slsfr_out_if.source         out_if
);
  import slsfr_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  slsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slsfr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .rx_data           (in_if.rx_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_payload_byte  (out_if.payload_byte),
    .out_byte_position (out_if.byte_position),
    .out_frame_length  (out_if.frame_length),
    .out_last          (out_if.last)
  );

endmodule

// ===== verif/sync_length_sum_frame_receiver_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver_unit_tb
// Self-checking bench for the two-byte sync, length and checksum deframer.
// A shadow deframer follows every accepted byte and queues the payload bytes
// that a good frame must produce. Each output transaction is compared field
// by field with the oldest queued one. Directed frames cover the field
// extremes and the drop cases. Random traffic runs under several register
// settings, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_receiver_unit_tb;
  import slsfr_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;
  localparam reg_idx_t REG_SPARE = 2'd3;  // unmapped index, writes are dropped

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_CHECK
  } rx_phase_e;

  typedef struct packed {
    byte_t payload_byte;
    addr_t byte_position;
    len_t  frame_length;
    logic  last;
  } payload_beat_t;

  typedef byte_t byte_q_t[$];

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  reg_idx_t cfg_index;
  byte_t    cfg_wdata;

  slsfr_in_if  rx_ch ();
  slsfr_out_if beat_ch ();

  sync_length_sum_frame_receiver_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (rx_ch.sink),
    .out_if    (beat_ch.source)
  );

  // shadow deframer: registers and state
  byte_t     sh_first_sync;
  byte_t     sh_second_sync;
  len_t      sh_limit;
  rx_phase_e sh_phase;
  len_t      sh_len;
  len_t      sh_count;
  byte_t     sh_sum;
  byte_t     sh_store [MAX_PAYLOAD];

  payload_beat_t beat_q[$];

  int err_cnt      = 0;
  int bytes_sent   = 0;
  int quiet_cycles = 0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;
  bit hold_req     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_limit();
    return (sh_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(sh_limit);
  endfunction

  // advance the shadow by one received byte, queue payload on a good check
  function automatic void deframe_byte(byte_t b);
    payload_beat_t beat;
    case (sh_phase)
      HUNT_SECOND: sh_phase = (b == sh_second_sync) ? GET_LENGTH : HUNT_FIRST;
      GET_LENGTH: begin
        sh_len = len_t'(b);
        if (b != 0 && int'(b) <= eff_limit()) begin
          sh_count = '0;
          sh_sum   = '0;
          sh_phase = GET_PAYLOAD;
        end else begin
          sh_phase = HUNT_FIRST;
        end
      end
      GET_PAYLOAD: begin
        if (sh_count < MAX_PAYLOAD) sh_store[sh_count[ADDR_W-1:0]] = b;
        sh_sum   = sh_sum + b;
        sh_count = len_t'(sh_count + 1);
        if (sh_count >= sh_len) sh_phase = GET_CHECK;
      end
      GET_CHECK: begin
        if (b == sh_sum) begin
          for (int i = 0; i < int'(sh_len); i++) begin
            beat.payload_byte  = sh_store[i];
            beat.byte_position = addr_t'(i);
            beat.frame_length  = sh_len;
            beat.last          = (i == int'(sh_len) - 1);
            beat_q.push_back(beat);
          end
        end
        sh_phase = HUNT_FIRST;
      end
      default: sh_phase = (b == sh_first_sync) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // one received byte; valid is left high for a following transaction
  task automatic send_byte(input byte_t b);
    if (!src_steady && $urandom_range(99) < 5) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_data <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input byte_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FIRST_SYNC:   sh_first_sync  = val;
      REG_SECOND_SYNC:  sh_second_sync = val;
      REG_LENGTH_LIMIT: sh_limit       = len_t'(val);
      default: ;
    endcase
  endtask

  task automatic send_header(input byte_t len_byte);
    send_byte(sh_first_sync);
    send_byte(sh_second_sync);
    send_byte(len_byte);
  endtask

  task automatic send_frame(input byte_q_t body, input bit bad_sum);
    byte_t sum;
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    send_header(byte_t'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(bad_sum ? (sum ^ byte_t'($urandom_range(255, 1))) : sum);
  endtask

  function automatic byte_q_t rand_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(byte_t'($urandom_range(255)));
    return q;
  endfunction

  // mostly short payloads, now and then up to the limit
  function automatic int rand_len();
    int lim;
    lim = (eff_limit() < 1) ? 1 : eff_limit();
    if ($urandom_range(9) == 0) return $urandom_range(lim, 1);
    return $urandom_range((lim < 8) ? lim : 8, 1);
  endfunction

  // feed filler until the shadow is hunting again
  task automatic to_hunt();
    byte_t b;
    while (sh_phase != HUNT_FIRST) begin
      do b = byte_t'($urandom_range(255)); while (b == sh_first_sync);
      send_byte(b);
    end
  endtask

  task automatic run_mixed_traffic(input int n_bytes);
    int    stop_at;
    int    pick;
    byte_t b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      to_hunt();
      if (pick < 70) begin
        send_frame(rand_body(rand_len()), 1'b0);
      end else if (pick < 80) begin
        send_frame(rand_body(rand_len()), 1'b1);
      end else if (pick < 85) begin
        send_byte(sh_first_sync);
        do b = byte_t'($urandom_range(255)); while (b == sh_second_sync);
        send_byte(b);
      end else if (pick < 90) begin
        b = $urandom_range(1) ? 8'h00 : byte_t'($urandom_range(255, eff_limit() + 1));
        send_header(b);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(byte_t'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_directed_frames();
    byte_q_t body;
    body = {8'hFF};
    send_frame(body, 1'b0);
    body = {8'h00};
    send_frame(body, 1'b0);
    body = {8'hFF, 8'h01};           // sum wraps to zero
    send_frame(body, 1'b0);
    body = {8'h5A};
    send_frame(body, 1'b1);
    // first sync again where the second is due, then a lone second sync
    send_byte(sh_first_sync);
    send_byte(sh_first_sync);
    send_byte(sh_second_sync);
    send_header(8'h00);
    send_header(8'd33);
    to_hunt();
    settle();
  endtask

  task automatic test_random_traffic();
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    run_mixed_traffic(10);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    run_mixed_traffic(15);
    to_hunt();
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_FIRST_SYNC, 8'h00);
    write_reg(REG_SECOND_SYNC, 8'hFF);
    write_reg(REG_LENGTH_LIMIT, 8'd1);
    send_frame(rand_body(1), 1'b0);
    send_header(8'd2);
    to_hunt();
    settle();

    // equal sync values; limit above 32 acts as 32
    write_reg(REG_FIRST_SYNC, 8'h55);
    write_reg(REG_SECOND_SYNC, 8'h55);
    write_reg(REG_LENGTH_LIMIT, 8'h3F);
    send_header(8'h55);
    to_hunt();
    send_frame(rand_body(MAX_PAYLOAD), 1'b0);
    send_header(8'd33);
    to_hunt();
    settle();

    // upper data bits are dropped: limit becomes zero and every frame is lost
    write_reg(REG_LENGTH_LIMIT, 8'hC0);
    send_frame(rand_body(1), 1'b0);
    to_hunt();
    settle();

    write_reg(REG_SPARE, 8'hA5);
    write_reg(REG_LENGTH_LIMIT, 8'hE5);
    write_reg(REG_FIRST_SYNC, byte_t'($urandom_range(255)));
    write_reg(REG_SECOND_SYNC, byte_t'($urandom_range(255)));
    run_mixed_traffic(8);
    to_hunt();
    settle();

    write_reg(REG_FIRST_SYNC, FIRST_SYNC_RST);
    write_reg(REG_SECOND_SYNC, SECOND_SYNC_RST);
    write_reg(REG_LENGTH_LIMIT, byte_t'(LENGTH_LIMIT_RST));
  endtask

  // a frame already past its length byte keeps its length
  task automatic test_limit_mid_frame();
    byte_q_t body;
    byte_t   sum;
    body = rand_body(8);
    sum  = '0;
    foreach (body[i]) sum = sum + body[i];
    send_header(8'd8);
    for (int i = 0; i < 4; i++) send_byte(body[i]);
    settle();
    write_reg(REG_LENGTH_LIMIT, 8'd4);
    for (int i = 4; i < 8; i++) send_byte(body[i]);
    send_byte(sum);
    send_header(8'd5);
    to_hunt();
    send_frame(rand_body(4), 1'b0);
    settle();
    write_reg(REG_LENGTH_LIMIT, byte_t'(LENGTH_LIMIT_RST));
  endtask

  // output held off while frames keep coming, then a full drain
  task automatic test_output_holdoff();
    hold_req   = 1'b1;
    src_steady = 1'b1;
    repeat (2) send_frame(rand_body($urandom_range(8, 4)), 1'b0);
    src_steady = 1'b0;
    settle();
  endtask

  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    beat_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        beat_ch.ready <= 1'b0;
      end else begin
        beat_ch.ready <= sink_steady || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin : beat_check
    payload_beat_t want;
    if (rst_n === 1'b1 && beat_ch.valid === 1'b1 && beat_ch.ready === 1'b1) begin
      if (beat_q.size() == 0) begin
        report_mismatch("transaction with nothing expected", beat_ch.payload_byte, 0);
      end else begin
        want = beat_q.pop_front();
        if (beat_ch.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", beat_ch.payload_byte, want.payload_byte);
        if (beat_ch.byte_position !== want.byte_position)
          report_mismatch("byte_position", beat_ch.byte_position, want.byte_position);
        if (beat_ch.frame_length !== want.frame_length)
          report_mismatch("frame_length", beat_ch.frame_length, want.frame_length);
        if (beat_ch.last !== want.last)
          report_mismatch("last", beat_ch.last, want.last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (rx_ch.valid && rx_ch.ready) || (beat_ch.valid && beat_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_FIRST_SYNC;
    cfg_wdata     <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_data <= '0;
    sh_first_sync  = FIRST_SYNC_RST;
    sh_second_sync = SECOND_SYNC_RST;
    sh_limit       = LENGTH_LIMIT_RST;
    sh_phase       = HUNT_FIRST;
    sh_len         = '0;
    sh_count       = '0;
    sh_sum         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_traffic();
    test_register_extremes();
    test_limit_mid_frame();
    test_output_holdoff();

    settle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
